// ===== rtl/keyed_merge_policy_table_macros.svh =====
// ---------------------------------------------------------------------------
// keyed merge policy table assertion macros
// shared property forms for the merge table checks
// ---------------------------------------------------------------------------
`ifndef KEYED_MERGE_POLICY_TABLE_MACROS_SVH
`define KEYED_MERGE_POLICY_TABLE_MACROS_SVH

// same-cycle implication
`define KMPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmpt check failed");

// next-cycle implication
`define KMPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmpt check failed");

`endif

// ===== rtl/kmpt_pkg.sv =====
// ---------------------------------------------------------------------------
// kmpt_pkg
// types, constants and saturation helpers for the keyed merge table
// ---------------------------------------------------------------------------
package kmpt_pkg;

  localparam int NUM_POINTS_DEF = 1024;

  localparam int IDX_W  = 10;
  localparam int Q_W    = 32;
  localparam int SRC_W  = 8;
  localparam int VAL_W  = 40;
  localparam int CNT_W  = 9;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFLICT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID  = 2'd2;

  localparam logic [2:0] POL_FIRST  = 3'd0;
  localparam logic [2:0] POL_LAST   = 3'd1;
  localparam logic [2:0] POL_LOWEST = 3'd2;
  localparam logic [2:0] POL_SUM    = 3'd3;
  localparam logic [2:0] POL_AVG    = 3'd4;
  localparam logic [2:0] POL_MIN    = 3'd5;
  localparam logic [2:0] POL_MAX    = 3'd6;
  localparam logic [2:0] POL_RSVD   = 3'd7;

  localparam logic KIND_MERGE   = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

  localparam logic signed [VAL_W:0] ACC_HI = 41'sd549755813887;
  localparam logic signed [VAL_W:0] ACC_LO = -41'sd549755813888;
  localparam logic signed [VAL_W:0] Q_HI   = 41'sd2147483647;
  localparam logic signed [VAL_W:0] Q_LO   = -41'sd2147483648;

  typedef struct packed {
    logic                    valid;
    logic [CNT_W-1:0]        count;
    logic [SRC_W-1:0]        source;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  function automatic logic signed [VAL_W-1:0] sat_acc(input logic signed [VAL_W:0] v);
    return (v > ACC_HI) ? $signed({1'b0, {(VAL_W-1){1'b1}}}) :
           (v < ACC_LO) ? $signed({1'b1, {(VAL_W-1){1'b0}}}) :
           $signed(v[VAL_W-1:0]);
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [VAL_W:0] v);
    return (v > Q_HI) ? $signed({1'b0, {(Q_W-1){1'b1}}}) :
           (v < Q_LO) ? $signed({1'b1, {(Q_W-1){1'b0}}}) :
           $signed(v[Q_W-1:0]);
  endfunction

endpackage

// ===== rtl/keyed_merge_policy_table.sv =====
// ---------------------------------------------------------------------------
// keyed_merge_policy_table
// per-point merge table combining candidate values under a chosen policy
// ---------------------------------------------------------------------------
// Input beats carry a merge candidate or a resolve request (in_tuser = kind).
// Every input beat gives exactly one output beat, in order.
// The entry store is one single-port-read memory; each item reads its entry,
// updates it and writes it back before the next item is taken, so items are
// handled one at a time.
// A merge, or a resolve under any policy but average, passes from the input
// beat through the EXEC and RESP states to the output register; an average
// resolve also passes through DIV for the bit-serial divider (one quotient
// bit per cycle, 40 bits). Items are not overlapped in the pipeline.
// Reset: control and registers return to their defaults and a clearing
// pass writes every entry to zero, with in_tready low meanwhile;
// configuration writes are taken during it.
// A stalled receiver holds the finished beat in the output register; one
// more item is taken and processed, then the block waits for the output.
// ---------------------------------------------------------------------------
module keyed_merge_policy_table #(
  parameter int NUM_POINTS = kmpt_pkg::NUM_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_index, candidate_valid, candidate_value, source_id, zero pad
  input  logic [kmpt_pkg::IN_W-1:0]       in_tdata,
  // kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // resolved_value, point_resolved, conflict_error, zero pad
  output logic [kmpt_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [kmpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  `include "keyed_merge_policy_table_macros.svh"

  localparam int IW = kmpt_pkg::IDX_W;
  localparam int QW = kmpt_pkg::Q_W;
  localparam int SW = kmpt_pkg::SRC_W;
  localparam int VW = kmpt_pkg::VAL_W;
  localparam int CW = kmpt_pkg::CNT_W;
  localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_POINTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  kmpt_pkg::entry_t mem [0:NUM_POINTS-1];
  kmpt_pkg::entry_t rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  kmpt_pkg::entry_t mem_wdata;

  logic [AW-1:0] clr_addr_r;

  logic [2:0]           policy_r;
  logic                 chk_r;
  logic signed [QW-1:0] invalid_r;

  logic                 kind_r;
  logic [IW-1:0]        idx_r;
  logic                 cvalid_r;
  logic signed [QW-1:0] cval_r;
  logic [SW-1:0]        src_r;

  logic [QW-1:0] res_value_r;
  logic          res_resolved_r;
  logic          res_conflict_r;
  logic          neg_r;

  logic                      out_valid_r;
  logic [kmpt_pkg::OUT_W-1:0] out_data_r;

  logic          accept;
  logic          out_free;
  logic [IW-1:0] in_idx;
  logic [AW+IW-1:0] in_idx_wide;
  logic [AW+IW-1:0] idx_wide;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] exec_addr;
  logic          idx_ok;

  logic signed [VW-1:0] cval_ext;
  logic signed [VW-1:0] inv_ext;
  logic signed [VW:0]   sum_full;
  logic                 additive;
  logic                 merge_do;
  logic                 conflict;
  logic                 take;
  logic                 need_div;
  kmpt_pkg::entry_t     take_e;
  kmpt_pkg::entry_t     sum_e;
  kmpt_pkg::entry_t     new_e;
  logic [QW-1:0]        res_direct;
  logic [VW-1:0]        mag;
  logic [CW-1:0]        dvs;
  logic                 div_done;
  logic [VW-1:0]        quot;
  logic signed [VW:0]   quot_s;

  assign accept      = in_tvalid && in_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_tready;
  assign in_idx      = in_tdata[IW-1:0];
  assign in_idx_wide = {{AW{1'b0}}, in_idx};
  assign idx_wide    = {{AW{1'b0}}, idx_r};
  assign in_addr     = in_idx_wide[AW-1:0];
  assign exec_addr   = idx_wide[AW-1:0];
  assign idx_ok      = 32'(idx_r) < 32'(NUM_POINTS);

  // entry store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= kmpt_pkg::POL_FIRST;
      chk_r     <= 1'b1;
      invalid_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kmpt_pkg::REG_POLICY:   policy_r  <= cfg_wdata[2:0];
        kmpt_pkg::REG_CONFLICT: chk_r     <= cfg_wdata[0];
        kmpt_pkg::REG_INVALID:  invalid_r <= $signed(cfg_wdata[QW-1:0]);
        default: ;
      endcase
    end
  end

  // merge and resolve datapath
  assign cval_ext = {{(VW-QW){cval_r[QW-1]}}, cval_r};
  assign inv_ext  = {{(VW-QW){invalid_r[QW-1]}}, invalid_r};
  assign sum_full = {rd_data_r.value[VW-1], rd_data_r.value} + {cval_ext[VW-1], cval_ext};
  assign additive = (policy_r == kmpt_pkg::POL_SUM) || (policy_r == kmpt_pkg::POL_AVG);
  assign merge_do = (kind_r == kmpt_pkg::KIND_MERGE) && cvalid_r && idx_ok &&
                    (policy_r != kmpt_pkg::POL_RSVD);
  assign conflict = merge_do && chk_r && rd_data_r.valid && !additive;

  always_comb begin
    case (policy_r)
      kmpt_pkg::POL_FIRST:  take = !rd_data_r.valid || (rd_data_r.value == inv_ext);
      kmpt_pkg::POL_LAST:   take = 1'b1;
      kmpt_pkg::POL_LOWEST: take = !rd_data_r.valid || (src_r < rd_data_r.source);
      kmpt_pkg::POL_MIN:    take = !rd_data_r.valid || (cval_ext < rd_data_r.value);
      kmpt_pkg::POL_MAX:    take = !rd_data_r.valid || (cval_ext > rd_data_r.value);
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    take_e.valid  = 1'b1;
    take_e.count  = CW'(1);
    take_e.source = src_r;
    take_e.value  = cval_ext;
    sum_e.valid   = 1'b1;
    sum_e.count   = (rd_data_r.count < kmpt_pkg::COUNT_MAX) ? rd_data_r.count + 1'b1
                                                           : rd_data_r.count;
    sum_e.source  = rd_data_r.source;
    sum_e.value   = kmpt_pkg::sat_acc(sum_full);
    new_e = additive ? sum_e : (take ? take_e : rd_data_r);
  end

  assign res_direct = (!idx_ok || !rd_data_r.valid) ? invalid_r
                    : kmpt_pkg::sat_q({rd_data_r.value[VW-1], rd_data_r.value});
  assign need_div   = (kind_r == kmpt_pkg::KIND_RESOLVE) && idx_ok && rd_data_r.valid &&
                      (policy_r == kmpt_pkg::POL_AVG);
  assign mag        = rd_data_r.value[VW-1] ? (~rd_data_r.value + 1'b1) : rd_data_r.value;
  assign dvs        = (rd_data_r.count == '0) ? CW'(1) : rd_data_r.count;
  assign quot_s     = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  kmpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == S_EXEC) && need_div),
    .dividend (mag),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quot)
  );

  // memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = exec_addr;
    mem_wdata = new_e;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == S_EXEC) begin
      if (kind_r == kmpt_pkg::KIND_RESOLVE) begin
        mem_we    = idx_ok;
        mem_wdata = '0;
      end else begin
        mem_we = merge_do && !conflict;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = need_div ? S_DIV : S_RESP;
      S_DIV:   if (div_done) state_nxt = S_RESP;
      S_RESP:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if ((state_r == S_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_tuser;
      idx_r    <= in_idx;
      cvalid_r <= in_tdata[IW];
      cval_r   <= $signed(in_tdata[IW+QW:IW+1]);
      src_r    <= in_tdata[IW+QW+SW:IW+QW+1];
    end
    if (state_r == S_EXEC) begin
      res_value_r    <= (kind_r == kmpt_pkg::KIND_RESOLVE) ? res_direct : '0;
      res_resolved_r <= (kind_r == kmpt_pkg::KIND_RESOLVE) && idx_ok && rd_data_r.valid;
      res_conflict_r <= conflict;
      neg_r          <= rd_data_r.value[VW-1];
    end else if ((state_r == S_DIV) && div_done) begin
      res_value_r <= kmpt_pkg::sat_q(quot_s);
    end
    if ((state_r == S_RESP) && out_free) begin
      out_data_r <= {{(kmpt_pkg::OUT_W-QW-2){1'b0}}, res_conflict_r, res_resolved_r,
                     res_value_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `KMPT_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC)
  `KMPT_ASSERT_NOW(a_div_in_div, div_done, state_r == S_DIV)
  `KMPT_ASSERT_NOW(a_result_flags, out_tvalid, !(out_tdata[QW] && out_tdata[QW+1]))
  `KMPT_ASSERT_NOW(a_write_owner, mem_we, (state_r == S_CLEAR) || (state_r == S_EXEC))

endmodule

// ===== rtl/kmpt_div.sv =====
// ---------------------------------------------------------------------------
// kmpt_div
// restoring divider, one quotient bit per cycle, unsigned magnitude
// ---------------------------------------------------------------------------
module kmpt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kmpt_pkg::VAL_W-1:0] dividend,
  input  logic [kmpt_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [kmpt_pkg::VAL_W-1:0] quotient
);

  localparam int VW     = kmpt_pkg::VAL_W;
  localparam int CW     = kmpt_pkg::CNT_W;
  localparam int STEP_W = $clog2(VW + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VW - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [VW-1:0]     dq_r;
  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     dvs_r;

  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          ge;
  logic [CW-1:0] rem_nxt;
  logic [VW-1:0] dq_nxt;

  assign trial   = {rem_r, dq_r[VW-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
  assign dq_nxt  = {dq_r[VW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule
